FILE: rtl/awsm_pkg.sv
// ----------------------------------------------------------------------------
// awsm_pkg: shared types and constants for the Ackermann wheel speed mapper
// Item layouts, configuration layout, register and state codes, the throttle
// mapping and the elaboration-time build of the inner/outer ratio table.
// ----------------------------------------------------------------------------
package awsm_pkg;

  localparam int unsigned RATIO_FRAC_BITS = 16;
  localparam int unsigned WHEELBASE_MM    = 1830;
  localparam int unsigned TRACK_MM        = 1640;
  localparam int unsigned MAX_STEER_DEG   = 30;

  localparam int unsigned RATIO_W     = RATIO_FRAC_BITS;
  localparam int unsigned RATIO_DEPTH = 128;
  localparam int unsigned RATIO_AW    = $clog2(RATIO_DEPTH);

  localparam int unsigned ID_W   = 11;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 11;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  localparam logic [BYTE_W-1:0] DIR_FWD      = 8'h07;
  localparam logic [BYTE_W-1:0] DIR_REV      = 8'h0B;
  localparam logic [BYTE_W-1:0] STEER_CENTER = 8'h7F;
  localparam logic [BYTE_W-1:0] SPEED_MAX    = 8'hFD;
  localparam logic [BYTE_W-1:0] THR_FULL     = 8'hFE;
  localparam logic [BYTE_W-1:0] SPEED_NONE   = 8'hFF;

  localparam logic [ID_W-1:0]   RST_JOYSTICK_ID = 11'h186;
  localparam logic [ID_W-1:0]   RST_STATUS_L    = 11'h201;
  localparam logic [ID_W-1:0]   RST_STATUS_R    = 11'h202;
  localparam logic [ID_W-1:0]   RST_COMMAND_L   = 11'h301;
  localparam logic [ID_W-1:0]   RST_COMMAND_R   = 11'h302;
  localparam logic [BYTE_W-1:0] RST_MODE        = 8'h05;

  typedef enum logic [2:0] {
    CFG_JOYSTICK_ID = 3'd0,
    CFG_STATUS_L    = 3'd1,
    CFG_STATUS_R    = 3'd2,
    CFG_COMMAND_L   = 3'd3,
    CFG_COMMAND_R   = 3'd4,
    CFG_MODE        = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ADDR_DIR_L  = 2'd0,
    ADDR_DIR_R  = 2'd1,
    ADDR_LAST_L = 2'd2,
    ADDR_LAST_R = 2'd3
  } st_addr_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIR_L,
    ST_DIR_R,
    ST_LAST_L,
    ST_LAST_R,
    ST_EMIT_L,
    ST_EMIT_R
  } core_state_e;

  typedef struct packed {
    logic [ID_W-1:0]   frame_id;
    logic [BYTE_W-1:0] data_byte0;
    logic [BYTE_W-1:0] data_byte1;
    logic [BYTE_W-1:0] data_byte3;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   out_frame_id;
    logic [BYTE_W-1:0] out_speed;
    logic [BYTE_W-1:0] out_mode;
    logic              out_last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   joystick_frame_id;
    logic [ID_W-1:0]   status_id_left;
    logic [ID_W-1:0]   status_id_right;
    logic [ID_W-1:0]   command_id_left;
    logic [ID_W-1:0]   command_id_right;
    logic [BYTE_W-1:0] command_mode_byte;
  } cfg_t;

  typedef logic [RATIO_W-1:0] ratio_rom_t [RATIO_DEPTH];

  // Throttle to wheel speed. Inside the linear span floor(x*253/127) is 2x-1.
  function automatic logic [BYTE_W-1:0] map_throttle(logic [BYTE_W-1:0] v,
                                                     logic [BYTE_W-1:0] dir);
    logic [BYTE_W:0] two_v;
    logic [BYTE_W:0] tmp;
    two_v = {v, 1'b0};
    tmp   = '0;
    if (dir == DIR_FWD) begin
      if (v <= STEER_CENTER) tmp = '0;
      else if (v >= THR_FULL) tmp = {1'b0, SPEED_MAX};
      else tmp = two_v - 9'd255;
    end else if (dir == DIR_REV) begin
      if (v == '0) tmp = {1'b0, SPEED_MAX};
      else if (v >= STEER_CENTER) tmp = '0;
      else tmp = 9'd254 - two_v;
    end
    return tmp[BYTE_W-1:0];
  endfunction

  // Restoring shift-subtract division, used only while the table is built.
  function automatic logic [63:0] div_u64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Ratio (2W cos a - T sin a)/(2W cos a + T sin a), series sin/cos in Q30.
  function automatic ratio_rom_t build_ratio_rom();
    ratio_rom_t      rom;
    logic [63:0]     x, x2, t, n, dd, r, maxr, du;
    longint          s, c, num, den;
    maxr = (64'd1 << RATIO_FRAC_BITS) - 64'd1;
    for (int d = 1; d <= RATIO_DEPTH; d++) begin
      du = 64'(d);
      x  = div_u64(PI_Q30 * 64'(MAX_STEER_DEG) * du, 64'd22860);
      x2 = (x * x) >> 30;
      t  = x;
      s  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        t = div_u64((t * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
        s = (k % 2 == 1) ? s - longint'(t) : s + longint'(t);
      end
      t = ONE_Q30;
      c = longint'(ONE_Q30);
      for (int k = 1; k <= 6; k++) begin
        t = div_u64((t * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
        c = (k % 2 == 1) ? c - longint'(t) : c + longint'(t);
      end
      num = longint'(2 * WHEELBASE_MM) * c - longint'(TRACK_MM) * s;
      den = longint'(2 * WHEELBASE_MM) * c + longint'(TRACK_MM) * s;
      r   = '0;
      if (num > 0 && (den >>> 10) > 0) begin
        n  = unsigned'(num >>> 10);
        dd = unsigned'(den >>> 10);
        r  = div_u64((n << RATIO_FRAC_BITS) + (dd >> 1), dd);
        if (r > maxr) r = maxr;
      end
      rom[d-1] = r[RATIO_W-1:0];
    end
    return rom;
  endfunction

endpackage

FILE: rtl/ackermann_wheel_speed_mapper.sv
// ----------------------------------------------------------------------------
// ackermann_wheel_speed_mapper: CAN joystick to per-wheel speed commands
// Configuration registers and the frame processing core.
// ----------------------------------------------------------------------------
// A motor status frame stores that wheel's direction. After a joystick frame
// is accepted, input ready stays low until the sequencer is done: it reads the
// four-entry state memory one entry a cycle (left and right direction, then
// left and right last-sent speed), scales the inner wheel through the shared
// ratio multiplier, and then has one emit state per wheel that places its
// command, if changed, in the output register, waiting there while the output
// side still holds the previous item. Frames with unknown identifiers are
// dropped. Up to two command items leave per joystick frame, left first, the
// final one flagged by out_last. The ratio table is fixed at elaboration and
// needs no clearing pass after reset.
module ackermann_wheel_speed_mapper import awsm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.joystick_frame_id <= RST_JOYSTICK_ID;
      cfg_q.status_id_left    <= RST_STATUS_L;
      cfg_q.status_id_right   <= RST_STATUS_R;
      cfg_q.command_id_left   <= RST_COMMAND_L;
      cfg_q.command_id_right  <= RST_COMMAND_R;
      cfg_q.command_mode_byte <= RST_MODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_JOYSTICK_ID: cfg_q.joystick_frame_id <= cfg_data_i;
        CFG_STATUS_L:    cfg_q.status_id_left    <= cfg_data_i;
        CFG_STATUS_R:    cfg_q.status_id_right   <= cfg_data_i;
        CFG_COMMAND_L:   cfg_q.command_id_left   <= cfg_data_i;
        CFG_COMMAND_R:   cfg_q.command_id_right  <= cfg_data_i;
        CFG_MODE:        cfg_q.command_mode_byte <= cfg_data_i[BYTE_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  awsm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/awsm_ratio_rom.sv
// ----------------------------------------------------------------------------
// awsm_ratio_rom: inner/outer wheel ratio table
// Synchronous read; contents fixed at elaboration.
// ----------------------------------------------------------------------------
module awsm_ratio_rom import awsm_pkg::*; (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [RATIO_AW-1:0] rd_addr_i,
  output logic [RATIO_W-1:0]  rd_data_o
);

  localparam ratio_rom_t RatioRom = build_ratio_rom();

  logic [RATIO_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= RatioRom[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/awsm_core.sv
// ----------------------------------------------------------------------------
// awsm_core: frame decode, wheel state memory and command sequencer
// Direction and last-sent speed bytes live in a four-entry synchronous memory
// that the sequencer reads one entry a cycle and writes back on change.
// ----------------------------------------------------------------------------
module awsm_core import awsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  core_state_e state_q, state_d;

  // state memory
  logic [BYTE_W-1:0] mem_q [4];
  logic [3:0]        mem_valid_q;
  logic [BYTE_W-1:0] rd_data_q;
  logic              mem_we, rd_en;
  st_addr_e          mem_waddr, rd_addr;
  logic [BYTE_W-1:0] mem_wdata;

  // ratio table
  logic                rom_en;
  logic [RATIO_AW-1:0] rom_addr;
  logic [RATIO_W-1:0]  rom_data;
  logic [BYTE_W-1:0]   rom_off;

  logic [BYTE_W-1:0] thr_q, steer_q;
  logic [BYTE_W-1:0] base_l_q, base_r_q, spd_l_q, spd_r_q;
  logic              emit_l_q, emit_r_q;
  logic              out_valid_q;
  out_item_t         out_item_q, out_item_d;

  logic accept, hit_l, hit_r, hit_j;
  logic latch_item, ld_base_l, ld_base_r, ld_spd_l, ld_spd_r, ld_emit_l, ld_emit_r;
  logic out_load, slot_free;
  logic steer_left, steer_right;

  logic [BYTE_W-1:0]          mul_base;
  logic [RATIO_W+BYTE_W-1:0]  mul_prod;
  logic [BYTE_W-1:0]          mul_speed;
  logic [BYTE_W-1:0]          map_out;
  logic                       diff_last;

  assign accept = in_valid_i && in_ready_o;
  assign hit_l  = in_item_i.frame_id == cfg_i.status_id_left;
  assign hit_r  = !hit_l && (in_item_i.frame_id == cfg_i.status_id_right);
  assign hit_j  = !hit_l && !hit_r && (in_item_i.frame_id == cfg_i.joystick_frame_id);

  assign steer_left  = steer_q < STEER_CENTER;
  assign steer_right = steer_q > STEER_CENTER;

  // left inner: 126 - steer; right inner: steer - 128
  assign rom_off  = (in_item_i.data_byte3 < STEER_CENTER) ?
                    (STEER_CENTER - 8'd1 - in_item_i.data_byte3) : in_item_i.data_byte3;
  assign rom_addr = rom_off[RATIO_AW-1:0];

  awsm_ratio_rom u_rom (
    .clk_i     (clk_i),
    .rd_en_i   (rom_en),
    .rd_addr_i (rom_addr),
    .rd_data_o (rom_data)
  );

  // one shared multiplier: left speed in ST_DIR_R, right speed in ST_LAST_L
  assign mul_base  = (state_q == ST_DIR_R) ? base_l_q : base_r_q;
  assign mul_prod  = ({{RATIO_W{1'b0}}, mul_base} * {{BYTE_W{1'b0}}, rom_data})
                     + ((RATIO_W + BYTE_W)'(1) << (RATIO_FRAC_BITS - 1));
  assign mul_speed = mul_prod[RATIO_FRAC_BITS +: BYTE_W];

  assign map_out   = map_throttle(thr_q, rd_data_q);
  assign slot_free = !out_valid_q || out_ready_i;
  assign diff_last = ((state_q == ST_LAST_L) ? spd_l_q : spd_r_q) != rd_data_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept && hit_j) state_d = ST_DIR_L;
      ST_DIR_L:  state_d = ST_DIR_R;
      ST_DIR_R:  state_d = ST_LAST_L;
      ST_LAST_L: state_d = ST_LAST_R;
      ST_LAST_R: state_d = ST_EMIT_L;
      ST_EMIT_L: if (!emit_l_q || slot_free) state_d = ST_EMIT_R;
      ST_EMIT_R: if (!emit_r_q || slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ADDR_DIR_L;
    mem_wdata  = in_item_i.data_byte0;
    rd_en      = 1'b0;
    rd_addr    = ADDR_DIR_L;
    rom_en     = 1'b0;
    latch_item = 1'b0;
    ld_base_l  = 1'b0;
    ld_base_r  = 1'b0;
    ld_spd_l   = 1'b0;
    ld_spd_r   = 1'b0;
    ld_emit_l  = 1'b0;
    ld_emit_r  = 1'b0;
    out_load   = 1'b0;
    out_item_d = out_item_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (hit_l || hit_r) begin
            mem_we    = 1'b1;
            mem_waddr = hit_l ? ADDR_DIR_L : ADDR_DIR_R;
          end
          if (hit_j) begin
            rd_en      = 1'b1;
            rd_addr    = ADDR_DIR_L;
            rom_en     = 1'b1;
            latch_item = 1'b1;
          end
        end
      end
      ST_DIR_L: begin
        ld_base_l = 1'b1;
        rd_en     = 1'b1;
        rd_addr   = ADDR_DIR_R;
      end
      ST_DIR_R: begin
        ld_base_r = 1'b1;
        ld_spd_l  = 1'b1;
        rd_en     = 1'b1;
        rd_addr   = ADDR_LAST_L;
      end
      ST_LAST_L: begin
        ld_spd_r  = 1'b1;
        ld_emit_l = 1'b1;
        mem_we    = diff_last;
        mem_waddr = ADDR_LAST_L;
        mem_wdata = spd_l_q;
        rd_en     = 1'b1;
        rd_addr   = ADDR_LAST_R;
      end
      ST_LAST_R: begin
        ld_emit_r = 1'b1;
        mem_we    = diff_last;
        mem_waddr = ADDR_LAST_R;
        mem_wdata = spd_r_q;
      end
      ST_EMIT_L: begin
        if (emit_l_q && slot_free) begin
          out_load   = 1'b1;
          out_item_d = '{out_frame_id: cfg_i.command_id_left, out_speed: spd_l_q,
                         out_mode: cfg_i.command_mode_byte, out_last: !emit_r_q};
        end
      end
      ST_EMIT_R: begin
        if (emit_r_q && slot_free) begin
          out_load   = 1'b1;
          out_item_d = '{out_frame_id: cfg_i.command_id_right, out_speed: spd_r_q,
                         out_mode: cfg_i.command_mode_byte, out_last: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mem_valid_q <= '0;
      out_valid_q <= 1'b0;
      emit_l_q    <= 1'b0;
      emit_r_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) mem_valid_q[mem_waddr] <= 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (ld_emit_l) emit_l_q <= diff_last;
      if (ld_emit_r) emit_r_q <= diff_last;
    end
  end

  // unwritten entries read back as their reset value
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (rd_en) begin
      if (mem_valid_q[rd_addr]) rd_data_q <= mem_q[rd_addr];
      else if (rd_addr == ADDR_DIR_L || rd_addr == ADDR_DIR_R) rd_data_q <= DIR_FWD;
      else rd_data_q <= SPEED_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (latch_item) begin
      thr_q   <= in_item_i.data_byte1;
      steer_q <= in_item_i.data_byte3;
    end
    if (ld_base_l) base_l_q <= map_out;
    if (ld_base_r) base_r_q <= map_out;
    if (ld_spd_l)  spd_l_q  <= steer_left  ? mul_speed : base_l_q;
    if (ld_spd_r)  spd_r_q  <= steer_right ? mul_speed : base_r_q;
    if (out_load)  out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && rd_en |-> mem_waddr != rd_addr)
    else $error("state memory read and write hit the same entry");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_ready_i)
    else $error("output register overwritten while holding an item");

  a_left_not_last_then_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !out_item_d.out_last |=> state_q == ST_EMIT_R && emit_r_q)
    else $error("left command without last flag not followed by right command");

  a_speed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_item_d.out_speed <= SPEED_MAX)
    else $error("commanded speed out of range");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Ackermann wheel speed mapper
// Drives CAN frames through the valid/ready input channel and predicts the
// motor command items from a local model of the direction and last-speed
// state and of the steering ratio table. Every accepted command is checked
// field by field against the oldest prediction. Phases change the register
// setting and the idling on both channels, and one phase holds the output
// side off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_top;
  import awsm_pkg::*;

  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;

  class speed_cmd_scoreboard;
    cfg_t             cfg;
    logic [7:0]       dir_left, dir_right;
    logic [7:0]       sent_left, sent_right;
    logic [15:0]      ratio_tbl [128];
    out_item_t        pending_cmds [$];
    int               errors;

    function new();
      cfg.joystick_frame_id = 11'h186;
      cfg.status_id_left    = 11'h201;
      cfg.status_id_right   = 11'h202;
      cfg.command_id_left   = 11'h301;
      cfg.command_id_right  = 11'h302;
      cfg.command_mode_byte = 8'h05;
      dir_left   = DIR_FWD;
      dir_right  = DIR_FWD;
      sent_left  = 8'hFF;
      sent_right = 8'hFF;
      errors     = 0;
      build_ratio_table();
    endfunction

    // Inner/outer ratio per steering distance, sin/cos as Q30 series.
    function void build_ratio_table();
      logic [63:0] ang, ang2, term, nq, dq, rq, rmax;
      longint      sn, cs, numer, denom;
      rmax = (64'd1 << RATIO_FRAC_BITS) - 64'd1;
      for (int d = 1; d <= 128; d++) begin
        ang  = (PI_Q30 * 64'(MAX_STEER_DEG) * 64'(d)) / (64'd180 * 64'd127);
        ang2 = (ang * ang) >> 30;
        term = ang;
        sn   = longint'(ang);
        for (int k = 1; k <= 6; k++) begin
          term = ((term * ang2) >> 30) / 64'((2 * k) * (2 * k + 1));
          sn   = (k % 2 == 1) ? sn - longint'(term) : sn + longint'(term);
        end
        term = 64'd1 << 30;
        cs   = longint'(term);
        for (int k = 1; k <= 6; k++) begin
          term = ((term * ang2) >> 30) / 64'((2 * k - 1) * (2 * k));
          cs   = (k % 2 == 1) ? cs - longint'(term) : cs + longint'(term);
        end
        numer = longint'(2 * WHEELBASE_MM) * cs - longint'(TRACK_MM) * sn;
        denom = longint'(2 * WHEELBASE_MM) * cs + longint'(TRACK_MM) * sn;
        rq    = '0;
        if (numer > 0 && (denom >>> 10) > 0) begin
          nq = 64'(numer >>> 10);
          dq = 64'(denom >>> 10);
          rq = ((nq << RATIO_FRAC_BITS) + dq / 64'd2) / dq;
          if (rq > rmax) rq = rmax;
        end
        ratio_tbl[d-1] = rq[15:0];
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_JOYSTICK_ID: cfg.joystick_frame_id = data;
        CFG_STATUS_L:    cfg.status_id_left    = data;
        CFG_STATUS_R:    cfg.status_id_right   = data;
        CFG_COMMAND_L:   cfg.command_id_left   = data;
        CFG_COMMAND_R:   cfg.command_id_right  = data;
        CFG_MODE:        cfg.command_mode_byte = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] wheel_speed(logic [7:0] thr, logic [7:0] dir);
      int unsigned v;
      v = thr;
      if (dir == DIR_FWD) begin
        if (v <= 127) return 8'd0;
        if (v >= 254) return 8'd253;
        return 8'(((v - 127) * 253) / 127);
      end
      if (dir == DIR_REV) begin
        if (v == 0) return 8'd253;
        if (v >= 127) return 8'd0;
        return 8'(253 - (v * 253) / 127);
      end
      return 8'd0;
    endfunction

    function logic [7:0] scale_inner(logic [7:0] base, logic [15:0] ratio);
      logic [63:0] p;
      p = 64'(base) * 64'(ratio) + (64'd1 << (RATIO_FRAC_BITS - 1));
      return 8'(p >> RATIO_FRAC_BITS);
    endfunction

    // Predict the command items caused by one accepted frame.
    function void note_frame(in_item_t it);
      logic [7:0] spd_l, spd_r;
      logic       emit_l, emit_r;
      out_item_t  cmd;
      if (it.frame_id == cfg.status_id_left) begin
        dir_left = it.data_byte0;
        return;
      end
      if (it.frame_id == cfg.status_id_right) begin
        dir_right = it.data_byte0;
        return;
      end
      if (it.frame_id != cfg.joystick_frame_id) return;
      spd_l = wheel_speed(it.data_byte1, dir_left);
      spd_r = wheel_speed(it.data_byte1, dir_right);
      if (it.data_byte3 < STEER_CENTER)
        spd_l = scale_inner(spd_l, ratio_tbl[7'(STEER_CENTER - it.data_byte3 - 8'd1)]);
      else if (it.data_byte3 > STEER_CENTER)
        spd_r = scale_inner(spd_r, ratio_tbl[7'(it.data_byte3 - STEER_CENTER - 8'd1)]);
      emit_l = (spd_l != sent_left);
      emit_r = (spd_r != sent_right);
      if (emit_l) begin
        sent_left        = spd_l;
        cmd.out_frame_id = cfg.command_id_left;
        cmd.out_speed    = spd_l;
        cmd.out_mode     = cfg.command_mode_byte;
        cmd.out_last     = !emit_r;
        pending_cmds.push_back(cmd);
      end
      if (emit_r) begin
        sent_right       = spd_r;
        cmd.out_frame_id = cfg.command_id_right;
        cmd.out_speed    = spd_r;
        cmd.out_mode     = cfg.command_mode_byte;
        cmd.out_last     = 1'b1;
        pending_cmds.push_back(cmd);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_cmd(out_item_t got);
      out_item_t want;
      if (pending_cmds.size() == 0) begin
        report($sformatf("unexpected command id=%h speed=%0d", got.out_frame_id,
                         got.out_speed));
        return;
      end
      want = pending_cmds.pop_front();
      if (got.out_frame_id != want.out_frame_id)
        report($sformatf("frame id %h, want %h", got.out_frame_id, want.out_frame_id));
      if (got.out_speed != want.out_speed)
        report($sformatf("speed %0d, want %0d (id %h)", got.out_speed, want.out_speed,
                         want.out_frame_id));
      if (got.out_mode != want.out_mode)
        report($sformatf("mode %h, want %h", got.out_mode, want.out_mode));
      if (got.out_last !== want.out_last)
        report($sformatf("last %b, want %b (id %h)", got.out_last, want.out_last,
                         want.out_frame_id));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [2:0]       cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  in_item_t         in_item_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_item_t        out_item_o;

  speed_cmd_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  ackermann_wheel_speed_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output side: check accepted items, then pick the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_cmd(out_item_o);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic in_item_t mk(logic [10:0] id, logic [7:0] b0, logic [7:0] b1,
                                  logic [7:0] b3);
    in_item_t it;
    it.frame_id   = id;
    it.data_byte0 = b0;
    it.data_byte1 = b1;
    it.data_byte3 = b3;
    return it;
  endfunction

  function automatic logic [7:0] random_dir();
    int unsigned pick;
    pick = $urandom_range(9, 0);
    if (pick < 4) return DIR_FWD;
    if (pick < 8) return DIR_REV;
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic in_item_t random_frame();
    in_item_t    it;
    int unsigned pick;
    logic [7:0]  edges [8];
    edges = '{8'h00, 8'h01, 8'h7E, 8'h7F, 8'h80, 8'hFD, 8'hFE, 8'hFF};
    it = mk(11'($urandom_range(2047, 0)), 8'($urandom_range(255, 0)),
            8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    pick = $urandom_range(99, 0);
    if (pick < 12) begin
      it.frame_id   = sb.cfg.status_id_left;
      it.data_byte0 = random_dir();
    end else if (pick < 24) begin
      it.frame_id   = sb.cfg.status_id_right;
      it.data_byte0 = random_dir();
    end else if (pick < 82) begin
      it.frame_id = sb.cfg.joystick_frame_id;
      if ($urandom_range(3, 0) == 0) it.data_byte1 = edges[$urandom_range(7, 0)];
      pick = $urandom_range(7, 0);
      if (pick == 0) it.data_byte3 = STEER_CENTER;
      else if (pick == 1) it.data_byte3 = edges[$urandom_range(7, 0)];
    end
    return it;
  endfunction

  // Called right after a rising clock; returns once the block has accepted the item.
  task automatic send_frame(input in_item_t it);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_frame(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Wait for every predicted command, then let a dropped frame drain.
  task automatic wait_quiet();
    int guard;
    guard = 0;
    while (sb.pending_cmds.size() > 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_frames, input int idle_pct, input int stall_pct,
                           input int hold_at);
    in_item_t it;
    int       counted;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    counted = 0;
    while (counted < n_frames) begin
      if (counted == hold_at) hold_cycles = 300;
      it = random_frame();
      counted++;
      send_frame(it);
    end
    in_valid_i <= 1'b0;
    wait_quiet();
  endtask

  task automatic run_directed();
    logic [10:0] jid, sl, sr;
    jid = sb.cfg.joystick_frame_id;
    sl  = sb.cfg.status_id_left;
    sr  = sb.cfg.status_id_right;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_frame(mk(jid, 8'h00, 8'hFF, 8'h7F));
    send_frame(mk(jid, 8'hFF, 8'hFE, 8'h7F));   // same speeds: nothing sent
    send_frame(mk(jid, 8'h00, 8'h80, 8'h00));   // full left lock
    send_frame(mk(jid, 8'h00, 8'h7F, 8'hFF));
    send_frame(mk(jid, 8'h00, 8'hC0, 8'hFF));   // full right lock, last table entry
    send_frame(mk(sl, DIR_REV, 8'h00, 8'h00));
    send_frame(mk(sr, 8'h13, 8'hFF, 8'hFF));    // unknown code: stop
    send_frame(mk(jid, 8'h55, 8'h00, 8'h7F));
    send_frame(mk(jid, 8'hAA, 8'h01, 8'h7E));
    send_frame(mk(jid, 8'h00, 8'h7E, 8'h80));
    send_frame(mk(jid, 8'h00, 8'h7F, 8'h80));
    send_frame(mk(sr, DIR_REV, 8'hAA, 8'h55));
    send_frame(mk(jid, 8'hFF, 8'h40, 8'h00));
    send_frame(mk(11'h000, 8'hFF, 8'hFF, 8'hFF)); // unknown ids: drop
    send_frame(mk(11'h7FF, 8'h00, 8'h00, 8'h00));
    send_frame(mk(sl, DIR_FWD, 8'h00, 8'h00));
    send_frame(mk(sr, DIR_FWD, 8'h00, 8'h00));
    send_frame(mk(jid, 8'h00, 8'hFF, 8'h01));
    send_frame(mk(jid, 8'h00, 8'hFF, 8'hFE));
    send_frame(mk(jid, 8'h00, 8'hFF, 8'h7F));
    send_frame(mk(jid, 8'hFF, 8'h81, 8'h7F));
    in_valid_i <= 1'b0;
    wait_quiet();
  endtask

  initial begin
    sb             = new();
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_JOYSTICK_ID;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    out_ready_i    = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_phase(130, 0, 0, -1);

    // Extremes of every register but the right status id; mode data carries bits above the byte.
    write_reg(CFG_JOYSTICK_ID, 11'h7FF);
    write_reg(CFG_STATUS_L, 11'h000);
    write_reg(CFG_STATUS_R, 11'h555);
    write_reg(CFG_COMMAND_L, 11'h000);
    write_reg(CFG_COMMAND_R, 11'h7FF);
    write_reg(CFG_MODE, 11'h7FF);
    write_reg(CFG_SPARE_A, 11'h123);
    run_phase(200, 53, 0, -1);

    write_reg(CFG_JOYSTICK_ID, 11'h000);
    write_reg(CFG_STATUS_L, 11'h7FF);
    write_reg(CFG_STATUS_R, 11'h2AA);
    write_reg(CFG_COMMAND_L, 11'h7FF);
    write_reg(CFG_COMMAND_R, 11'h000);
    write_reg(CFG_MODE, 11'h000);
    write_reg(CFG_SPARE_B, 11'h7FF);
    run_phase(200, 0, 53, 50);

    // All three ids equal: only the left status match acts.
    write_reg(CFG_JOYSTICK_ID, 11'h123);
    write_reg(CFG_STATUS_L, 11'h123);
    write_reg(CFG_STATUS_R, 11'h123);
    run_phase(60, 16, 16, -1);

    // Right status shadows the joystick id.
    write_reg(CFG_STATUS_L, 11'h321);
    run_phase(60, 16, 16, -1);

    write_reg(CFG_JOYSTICK_ID, 11'($urandom_range(2047, 0)));
    write_reg(CFG_STATUS_L, 11'($urandom_range(2047, 0)));
    write_reg(CFG_STATUS_R, 11'($urandom_range(2047, 0)));
    write_reg(CFG_COMMAND_L, 11'($urandom_range(2047, 0)));
    write_reg(CFG_COMMAND_R, 11'($urandom_range(2047, 0)));
    write_reg(CFG_MODE, 11'($urandom_range(2047, 0)));
    run_phase(200, 16, 16, -1);

    write_reg(CFG_JOYSTICK_ID, RST_JOYSTICK_ID);
    write_reg(CFG_STATUS_L, RST_STATUS_L);
    write_reg(CFG_STATUS_R, RST_STATUS_R);
    write_reg(CFG_COMMAND_L, RST_COMMAND_L);
    write_reg(CFG_COMMAND_R, RST_COMMAND_R);
    write_reg(CFG_MODE, 11'(RST_MODE));
    run_phase(80, 0, 0, -1);

    if (sb.pending_cmds.size() > 0)
      sb.report($sformatf("%0d command items never arrived", sb.pending_cmds.size()));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
